[hdl/eba_pkg.sv]
`timescale 1ns / 1ps

package eba_pkg;

  typedef enum logic [4:0] {
    KIND_ADD  = 5'd0,
    KIND_ADC  = 5'd1,
    KIND_SUB  = 5'd2,
    KIND_SBC  = 5'd3,
    KIND_AND  = 5'd4,
    KIND_XOR  = 5'd5,
    KIND_OR   = 5'd6,
    KIND_CP   = 5'd7,
    KIND_INC  = 5'd8,
    KIND_DEC  = 5'd9,
    KIND_RLCA = 5'd10,
    KIND_RRCA = 5'd11,
    KIND_RLA  = 5'd12,
    KIND_RRA  = 5'd13,
    KIND_DAA  = 5'd14,
    KIND_CPL  = 5'd15,
    KIND_SCF  = 5'd16,
    KIND_CCF  = 5'd17,
    KIND_RLC  = 5'd18,
    KIND_RRC  = 5'd19,
    KIND_RL   = 5'd20,
    KIND_RR   = 5'd21,
    KIND_SLA  = 5'd22,
    KIND_SRA  = 5'd23,
    KIND_SWAP = 5'd24,
    KIND_SRL  = 5'd25,
    KIND_BIT  = 5'd26,
    KIND_RES  = 5'd27,
    KIND_SET  = 5'd28
  } kind_e;

  localparam logic [7:0] DaaLimit     = 8'h99;
  localparam logic [7:0] DaaCorrHigh  = 8'h60;
  localparam logic [7:0] DaaCorrLow   = 8'h06;
  localparam logic [3:0] NibbleLimit  = 4'd9;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] value;
    logic       write_back;
    flags_t     flags;
  } alu_res_t;

endpackage

[hdl/eba_alu.sv]
`timescale 1ns / 1ps

module eba_alu (
  input  logic [4:0]        kind_i,
  input  logic [7:0]        target_i,
  input  logic [7:0]        operand_i,
  input  logic [2:0]        bit_index_i,
  input  eba_pkg::flags_t   flags_i,
  output eba_pkg::alu_res_t res_o
);

  logic       ci_add;
  logic       ci_sub;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [9:0] sub_diff;
  logic [4:0] sub_half;
  logic [7:0] inc_val;
  logic [7:0] dec_val;
  logic [7:0] daa_corr;
  logic       daa_carry;
  logic [7:0] daa_val;
  logic [7:0] bit_mask;

  assign ci_add   = (kind_i == eba_pkg::KIND_ADC) ? flags_i.c : 1'b0;
  assign ci_sub   = (kind_i == eba_pkg::KIND_SBC) ? flags_i.c : 1'b0;
  assign add_sum  = {1'b0, target_i} + {1'b0, operand_i} + {8'd0, ci_add};
  assign add_half = {1'b0, target_i[3:0]} + {1'b0, operand_i[3:0]} + {4'd0, ci_add};
  // borrow shows up as the sign bit of the widened difference
  assign sub_diff = {2'b00, target_i} - {2'b00, operand_i} - {9'd0, ci_sub};
  assign sub_half = {1'b0, target_i[3:0]} - {1'b0, operand_i[3:0]} - {4'd0, ci_sub};
  assign inc_val  = target_i + 8'd1;
  assign dec_val  = target_i - 8'd1;
  assign bit_mask = 8'd1 << bit_index_i;

  always_comb begin
    daa_corr  = 8'd0;
    daa_carry = flags_i.c;
    if (!flags_i.n) begin
      if (flags_i.c || (target_i > eba_pkg::DaaLimit)) begin
        daa_corr  = daa_corr | eba_pkg::DaaCorrHigh;
        daa_carry = 1'b1;
      end
      if (flags_i.h || (target_i[3:0] > eba_pkg::NibbleLimit)) begin
        daa_corr = daa_corr | eba_pkg::DaaCorrLow;
      end
      daa_val = target_i + daa_corr;
    end else begin
      if (flags_i.c) begin
        daa_corr = daa_corr | eba_pkg::DaaCorrHigh;
      end
      if (flags_i.h) begin
        daa_corr = daa_corr | eba_pkg::DaaCorrLow;
      end
      daa_val = target_i - daa_corr;
    end
  end

  always_comb begin
    logic zres;
    zres             = 1'b1;
    res_o.value      = target_i;
    res_o.write_back = 1'b1;
    res_o.flags      = flags_i;
    unique case (eba_pkg::kind_e'(kind_i))
      eba_pkg::KIND_ADD, eba_pkg::KIND_ADC: begin
        res_o.value   = add_sum[7:0];
        res_o.flags.n = 1'b0;
        res_o.flags.h = add_half[4];
        res_o.flags.c = add_sum[8];
      end
      eba_pkg::KIND_SUB, eba_pkg::KIND_SBC: begin
        res_o.value   = sub_diff[7:0];
        res_o.flags.n = 1'b1;
        res_o.flags.h = sub_half[4];
        res_o.flags.c = sub_diff[9];
      end
      eba_pkg::KIND_CP: begin
        zres             = 1'b0;
        res_o.write_back = 1'b0;
        res_o.flags.z    = (sub_diff[7:0] == 8'd0);
        res_o.flags.n    = 1'b1;
        res_o.flags.h    = sub_half[4];
        res_o.flags.c    = sub_diff[9];
      end
      eba_pkg::KIND_AND: begin
        res_o.value = target_i & operand_i;
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b1;
        res_o.flags.c = 1'b0;
      end
      eba_pkg::KIND_XOR: begin
        res_o.value = target_i ^ operand_i;
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = 1'b0;
      end
      eba_pkg::KIND_OR: begin
        res_o.value = target_i | operand_i;
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = 1'b0;
      end
      eba_pkg::KIND_INC: begin
        res_o.value   = inc_val;
        res_o.flags.n = 1'b0;
        res_o.flags.h = (inc_val[3:0] == 4'h0);
      end
      eba_pkg::KIND_DEC: begin
        res_o.value   = dec_val;
        res_o.flags.n = 1'b1;
        res_o.flags.h = (dec_val[3:0] == 4'hF);
      end
      eba_pkg::KIND_RLCA, eba_pkg::KIND_RLC: begin
        res_o.value   = {target_i[6:0], target_i[7]};
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = target_i[7];
      end
      eba_pkg::KIND_RRCA, eba_pkg::KIND_RRC: begin
        res_o.value   = {target_i[0], target_i[7:1]};
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = target_i[0];
      end
      eba_pkg::KIND_RLA, eba_pkg::KIND_RL: begin
        res_o.value   = {target_i[6:0], flags_i.c};
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = target_i[7];
      end
      eba_pkg::KIND_RRA, eba_pkg::KIND_RR: begin
        res_o.value   = {flags_i.c, target_i[7:1]};
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = target_i[0];
      end
      eba_pkg::KIND_DAA: begin
        res_o.value   = daa_val;
        res_o.flags.h = 1'b0;
        res_o.flags.c = daa_carry;
      end
      eba_pkg::KIND_CPL: begin
        zres          = 1'b0;
        res_o.value   = ~target_i;
        res_o.flags.n = 1'b1;
        res_o.flags.h = 1'b1;
      end
      eba_pkg::KIND_SCF: begin
        zres             = 1'b0;
        res_o.write_back = 1'b0;
        res_o.flags.n    = 1'b0;
        res_o.flags.h    = 1'b0;
        res_o.flags.c    = 1'b1;
      end
      eba_pkg::KIND_CCF: begin
        zres             = 1'b0;
        res_o.write_back = 1'b0;
        res_o.flags.n    = 1'b0;
        res_o.flags.h    = 1'b0;
        res_o.flags.c    = ~flags_i.c;
      end
      eba_pkg::KIND_SLA: begin
        res_o.value   = {target_i[6:0], 1'b0};
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = target_i[7];
      end
      eba_pkg::KIND_SRA: begin
        res_o.value   = {target_i[7], target_i[7:1]};
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = target_i[0];
      end
      eba_pkg::KIND_SWAP: begin
        res_o.value   = {target_i[3:0], target_i[7:4]};
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = 1'b0;
      end
      eba_pkg::KIND_SRL: begin
        res_o.value   = {1'b0, target_i[7:1]};
        res_o.flags.n = 1'b0;
        res_o.flags.h = 1'b0;
        res_o.flags.c = target_i[0];
      end
      eba_pkg::KIND_BIT: begin
        zres             = 1'b0;
        res_o.write_back = 1'b0;
        res_o.flags.z    = ~target_i[bit_index_i];
        res_o.flags.n    = 1'b0;
        res_o.flags.h    = 1'b1;
      end
      eba_pkg::KIND_RES: begin
        zres        = 1'b0;
        res_o.value = target_i & ~bit_mask;
      end
      eba_pkg::KIND_SET: begin
        zres        = 1'b0;
        res_o.value = target_i | bit_mask;
      end
      default: begin
        // undefined kinds: no write, flags hold
        zres             = 1'b0;
        res_o.write_back = 1'b0;
      end
    endcase
    if (zres) begin
      res_o.flags.z = (res_o.value == 8'd0);
    end
    // accumulator rotates always clear Z
    if ((kind_i == eba_pkg::KIND_RLCA) || (kind_i == eba_pkg::KIND_RRCA) ||
        (kind_i == eba_pkg::KIND_RLA) || (kind_i == eba_pkg::KIND_RRA)) begin
      res_o.flags.z = 1'b0;
    end
  end

endmodule

[hdl/eight_bit_cpu_alu_with_flags.sv]
`timescale 1ns / 1ps
// Timing: an accepted word is held in the input register, passes through the ALU,
// is registered into the result register, and leaves from there when m_axis_tready is high.
// Throughput: one word per cycle unless the output stalls; the input register, ALU and result register
// form a two-stage pipe, and the flag register updates as each word leaves the ALU.
// Reset: asynchronous, active low; clears both valid bits and all four flags.

module eight_bit_cpu_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // target_value[7:0], operand_value[15:8], bit_index[18:16]
  input  logic [4:0]  s_axis_tuser,  // kind[4:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // result_value[7:0], zero[8], subtract[9], half[10], carry[11]
  output logic [0:0]  m_axis_tuser   // write_back[0]
);

  logic                in_valid_q;
  logic [4:0]          in_kind_q;
  logic [7:0]          in_target_q;
  logic [7:0]          in_operand_q;
  logic [2:0]          in_bit_q;
  eba_pkg::flags_t     flags_q;
  eba_pkg::flags_t     flags_d;
  eba_pkg::alu_res_t   alu_res;
  eba_pkg::alu_res_t   out_q;
  logic                out_valid_q;
  logic                out_valid_d;
  logic                advance;
  logic                in_take;

  // move the word from the input register into the result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  eba_alu u_alu (
    .kind_i      (in_kind_q),
    .target_i    (in_target_q),
    .operand_i   (in_operand_q),
    .bit_index_i (in_bit_q),
    .flags_i     (flags_q),
    .res_o       (alu_res)
  );

  assign flags_d     = advance ? alu_res.flags : flags_q;
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      in_valid_q  <= in_take || (in_valid_q && !advance);
      out_valid_q <= out_valid_d;
      flags_q     <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q    <= s_axis_tuser;
      in_target_q  <= s_axis_tdata[7:0];
      in_operand_q <= s_axis_tdata[15:8];
      in_bit_q     <= s_axis_tdata[18:16];
    end
    if (advance) begin
      out_q <= alu_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.flags.c, out_q.flags.h, out_q.flags.n, out_q.flags.z,
                          out_q.value};
  assign m_axis_tuser  = out_q.write_back;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import eba_pkg::*;

  localparam logic [4:0] KindSpareFirst = 5'd29;
  localparam logic [4:0] KindSpareLast  = 5'd31;
  localparam int         RandomOps      = 650;
  localparam int         CycleLimit     = 200_000;
  localparam int         HoldAtResult   = 150;
  localparam int         HoldCycles     = 40;

  typedef struct {
    logic [4:0] kind;
    logic [7:0] target;
    logic [7:0] operand;
    logic [2:0] bit_sel;
    bit         fixed;
    logic [12:0] want;
  } alu_op_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // target_value[7:0], operand_value[15:8], bit_index[18:16]
  logic [4:0]  s_axis_tuser;  // kind[4:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;  // result_value[7:0], zero[8], subtract[9], half[10], carry[11]
  logic [0:0]  m_axis_tuser;  // write_back[0]

  alu_op_t  alu_ops[$];
  alu_res_t alu_results_due[$];
  flags_t   flag_reg;
  int       mismatch_count;
  int       results_checked;
  int       ops_sent;
  bit [31:0] kinds_seen;
  int       cycle_count;

  eight_bit_cpu_alu_with_flags u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Compute the result word and advance the flag register.
  function automatic alu_res_t alu_predict(input logic [4:0] kind, input logic [7:0] a,
                                           input logic [7:0] b, input logic [2:0] bi);
    flags_t     f;
    logic [8:0] sum;
    logic [7:0] r;
    logic [7:0] corr;
    logic       wb;
    logic       zres;
    logic       ci;
    alu_res_t   res;
    f    = flag_reg;
    r    = a;
    wb   = 1'b1;
    zres = 1'b1;
    corr = 8'h00;
    ci   = 1'b0;
    case (kind)
      KIND_ADD, KIND_ADC: begin
        ci  = (kind == KIND_ADC) ? f.c : 1'b0;
        sum = {1'b0, a} + {1'b0, b} + ci;
        r   = sum[7:0];
        f.n = 1'b0;
        f.h = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + ci) > 5'h0F;
        f.c = sum[8];
      end
      KIND_SUB, KIND_SBC, KIND_CP: begin
        ci  = (kind == KIND_SBC) ? f.c : 1'b0;
        r   = a - b - ci;
        f.n = 1'b1;
        f.h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + ci);
        // borrow is taken on the nine-bit operand so 0xFF plus carry still borrows
        f.c = {1'b0, a} < ({1'b0, b} + ci);
        if (kind == KIND_CP) begin
          f.z  = (r == 8'h00);
          zres = 1'b0;
          r    = a;
          wb   = 1'b0;
        end
      end
      KIND_AND: begin r = a & b; f.n = 1'b0; f.h = 1'b1; f.c = 1'b0; end
      KIND_XOR: begin r = a ^ b; f.n = 1'b0; f.h = 1'b0; f.c = 1'b0; end
      KIND_OR:  begin r = a | b; f.n = 1'b0; f.h = 1'b0; f.c = 1'b0; end
      KIND_INC: begin r = a + 8'd1; f.n = 1'b0; f.h = (r[3:0] == 4'h0); end
      KIND_DEC: begin r = a - 8'd1; f.n = 1'b1; f.h = (r[3:0] == 4'hF); end
      KIND_RLCA, KIND_RLC: begin
        r = {a[6:0], a[7]}; f.c = a[7]; f.n = 1'b0; f.h = 1'b0;
      end
      KIND_RRCA, KIND_RRC: begin
        r = {a[0], a[7:1]}; f.c = a[0]; f.n = 1'b0; f.h = 1'b0;
      end
      KIND_RLA, KIND_RL: begin
        r = {a[6:0], f.c}; f.c = a[7]; f.n = 1'b0; f.h = 1'b0;
      end
      KIND_RRA, KIND_RR: begin
        r = {f.c, a[7:1]}; f.c = a[0]; f.n = 1'b0; f.h = 1'b0;
      end
      KIND_DAA: begin
        // both corrections test the incoming accumulator and flags
        if (!f.n) begin
          if (f.c || a > DaaLimit) begin
            corr = corr | DaaCorrHigh;
            f.c  = 1'b1;
          end
          if (f.h || a[3:0] > NibbleLimit) corr = corr | DaaCorrLow;
          r = a + corr;
        end else begin
          if (f.c) corr = corr | DaaCorrHigh;
          if (f.h) corr = corr | DaaCorrLow;
          r = a - corr;
        end
        f.h = 1'b0;
      end
      KIND_CPL: begin r = ~a; f.n = 1'b1; f.h = 1'b1; zres = 1'b0; end
      KIND_SCF: begin f.c = 1'b1; f.n = 1'b0; f.h = 1'b0; wb = 1'b0; zres = 1'b0; end
      KIND_CCF: begin f.c = ~f.c; f.n = 1'b0; f.h = 1'b0; wb = 1'b0; zres = 1'b0; end
      KIND_SLA: begin r = {a[6:0], 1'b0}; f.c = a[7]; f.n = 1'b0; f.h = 1'b0; end
      KIND_SRA: begin r = {a[7], a[7:1]}; f.c = a[0]; f.n = 1'b0; f.h = 1'b0; end
      KIND_SWAP: begin r = {a[3:0], a[7:4]}; f.c = 1'b0; f.n = 1'b0; f.h = 1'b0; end
      KIND_SRL: begin r = {1'b0, a[7:1]}; f.c = a[0]; f.n = 1'b0; f.h = 1'b0; end
      KIND_BIT: begin
        f.z = ~a[bi]; f.n = 1'b0; f.h = 1'b1; wb = 1'b0; zres = 1'b0;
      end
      KIND_RES: begin r = a & ~(8'd1 << bi); zres = 1'b0; end
      KIND_SET: begin r = a | (8'd1 << bi); zres = 1'b0; end
      default: begin wb = 1'b0; zres = 1'b0; end
    endcase
    if (zres) f.z = (r == 8'h00);
    if (kind == KIND_RLCA || kind == KIND_RRCA || kind == KIND_RLA || kind == KIND_RRA)
      f.z = 1'b0;
    flag_reg       = f;
    res.value      = r;
    res.write_back = wb;
    res.flags      = f;
    return res;
  endfunction

  function automatic alu_op_t mk_op(input logic [4:0] k, input logic [7:0] t,
                                    input logic [7:0] o, input logic [2:0] s,
                                    input bit fx, input logic [12:0] w);
    alu_op_t op;
    op.kind    = k;
    op.target  = t;
    op.operand = o;
    op.bit_sel = s;
    op.fixed   = fx;
    op.want    = w;
    return op;
  endfunction

  // Lean toward the bytes where carries, nibble limits and BCD limits sit.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h0F;
      3: return 8'h10;
      4: return 8'h7F;
      5: return 8'h80;
      6: return 8'h99;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_bcd();
    logic [3:0] hi;
    logic [3:0] lo;
    hi = 4'($urandom_range(0, 9));
    lo = 4'($urandom_range(0, 9));
    return {hi, lo};
  endfunction

  task automatic build_ops();
    int         count;
    int         sel;
    logic [7:0] a;
    logic [7:0] b;
    logic [4:0] k;
    count = 0;
    // directed rows; the last field is {value, write_back, Z N H C} where typed in
    alu_ops.push_back(mk_op(KIND_ADD,  8'h00, 8'h00, 3'd0, 1, {8'h00, 1'b1, 4'b1000}));
    alu_ops.push_back(mk_op(KIND_ADD,  8'hFF, 8'h01, 3'd7, 1, {8'h00, 1'b1, 4'b1011}));
    alu_ops.push_back(mk_op(KIND_ADC,  8'hFF, 8'h00, 3'd0, 1, {8'h00, 1'b1, 4'b1011}));
    // subtract with carry of 0xFF: the nine-bit borrow
    alu_ops.push_back(mk_op(KIND_SBC,  8'h00, 8'hFF, 3'd0, 1, {8'h00, 1'b1, 4'b1111}));
    alu_ops.push_back(mk_op(KIND_SUB,  8'h00, 8'h01, 3'd0, 1, {8'hFF, 1'b1, 4'b0111}));
    alu_ops.push_back(mk_op(KIND_AND,  8'hF0, 8'h0F, 3'd0, 1, {8'h00, 1'b1, 4'b1010}));
    alu_ops.push_back(mk_op(KIND_XOR,  8'hFF, 8'hFF, 3'd0, 1, {8'h00, 1'b1, 4'b1000}));
    alu_ops.push_back(mk_op(KIND_OR,   8'h00, 8'h80, 3'd0, 1, {8'h80, 1'b1, 4'b0000}));
    alu_ops.push_back(mk_op(KIND_CP,   8'h3C, 8'h3C, 3'd0, 1, {8'h3C, 1'b0, 4'b1100}));
    alu_ops.push_back(mk_op(KIND_INC,  8'hFF, 8'h00, 3'd0, 1, {8'h00, 1'b1, 4'b1010}));
    alu_ops.push_back(mk_op(KIND_DEC,  8'h00, 8'h00, 3'd0, 1, {8'hFF, 1'b1, 4'b0110}));
    alu_ops.push_back(mk_op(KIND_RLCA, 8'h80, 8'h00, 3'd0, 1, {8'h01, 1'b1, 4'b0001}));
    alu_ops.push_back(mk_op(KIND_RRCA, 8'h01, 8'h00, 3'd0, 1, {8'h80, 1'b1, 4'b0001}));
    alu_ops.push_back(mk_op(KIND_RLA,  8'h80, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_RRA,  8'h00, 8'h00, 3'd0, 0, '0));
    // decimal adjust after an add and after a subtract
    alu_ops.push_back(mk_op(KIND_ADD,  8'h99, 8'h01, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_DAA,  8'h9A, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_SUB,  8'h10, 8'h01, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_DAA,  8'h0F, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_CPL,  8'h5A, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_SCF,  8'h42, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_CCF,  8'h24, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_RLC,  8'h81, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_RRC,  8'h00, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_RL,   8'h80, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_RR,   8'h01, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_SLA,  8'h80, 8'h00, 3'd0, 1, {8'h00, 1'b1, 4'b1001}));
    alu_ops.push_back(mk_op(KIND_SRA,  8'h81, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_SWAP, 8'hF0, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_SRL,  8'h01, 8'h00, 3'd0, 1, {8'h00, 1'b1, 4'b1001}));
    alu_ops.push_back(mk_op(KIND_BIT,  8'h7F, 8'h00, 3'd7, 0, '0));
    alu_ops.push_back(mk_op(KIND_RES,  8'hFF, 8'h00, 3'd0, 0, '0));
    alu_ops.push_back(mk_op(KIND_SET,  8'h00, 8'h00, 3'd7, 0, '0));
    alu_ops.push_back(mk_op(KindSpareLast, 8'hA5, 8'h5A, 3'd3, 0, '0));

    while (count < RandomOps) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        k = 5'($urandom_range(KindSpareFirst, KindSpareLast));
        alu_ops.push_back(mk_op(k, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)), 0, '0));
        count++;
      end else if (sel < 15) begin
        // BCD arithmetic followed by an adjust of its result
        a = pick_bcd();
        b = pick_bcd();
        k = ($urandom_range(0, 1) != 0) ? KIND_SUB : KIND_ADD;
        alu_ops.push_back(mk_op(k, a, b, 3'($urandom_range(0, 7)), 0, '0));
        a = (k == KIND_ADD) ? a + b : a - b;
        alu_ops.push_back(mk_op(KIND_DAA, a, pick_byte(), 3'($urandom_range(0, 7)), 0, '0));
        count += 2;
      end else begin
        k = 5'($urandom_range(0, 28));
        alu_ops.push_back(mk_op(k, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)), 0, '0));
        count++;
      end
    end
  endtask

  task automatic drive_ops();
    int       gap;
    alu_op_t  op;
    alu_res_t due;
    for (int i = 0; i < alu_ops.size(); i++) begin
      op = alu_ops[i];
      // back-to-back stretch in every 128 words
      gap = (i % 128 >= 32 && i % 128 < 64) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {5'b0, op.bit_sel, op.operand, op.target};
      s_axis_tuser  <= op.kind;
      do @(posedge clk_i); while (!s_axis_tready);
      due = alu_predict(op.kind, op.target, op.operand, op.bit_sel);
      if (op.fixed) due = alu_res_t'(op.want);
      alu_results_due.push_back(due);
      kinds_seen[op.kind] = 1'b1;
      ops_sent++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    alu_res_t want;
    if (alu_results_due.size() == 0) begin
      $display("%0t: result word with nothing expected, actual %h/%h", $time,
               m_axis_tdata, m_axis_tuser);
      mismatch_count++;
    end else begin
      want = alu_results_due.pop_front();
      compare_field("result_value", want.value, m_axis_tdata[7:0]);
      compare_field("write_back", {7'b0, want.write_back}, {7'b0, m_axis_tuser[0]});
      compare_field("zero_flag", {7'b0, want.flags.z}, {7'b0, m_axis_tdata[8]});
      compare_field("subtract_flag", {7'b0, want.flags.n}, {7'b0, m_axis_tdata[9]});
      compare_field("half_flag", {7'b0, want.flags.h}, {7'b0, m_axis_tdata[10]});
      compare_field("carry_flag", {7'b0, want.flags.c}, {7'b0, m_axis_tdata[11]});
    end
    results_checked++;
  endtask

  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (results_checked == HoldAtResult) begin
        // long hold so the pipe fills and back-pressures the input
        stall = HoldCycles;
      end else if (results_checked % 100 >= 50 && results_checked % 100 < 80) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result();
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_count,
             alu_results_due.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    flag_reg        = '0;
    mismatch_count  = 0;
    results_checked = 0;
    ops_sent        = 0;
    kinds_seen      = '0;
    build_ops();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drive_ops();
    while (alu_results_due.size() != 0) @(posedge clk_i);
    // drain: any stray word after the last one shows up here
    repeat (8) @(posedge clk_i);
    $display("sent %0d words covering %0d of 32 kind codes, checked %0d results, %0d mismatches",
             ops_sent, $countones(kinds_seen), results_checked, mismatch_count);
    $display("output held off once for %0d cycles to back-pressure the input", HoldCycles);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/eba_pkg.sv
hdl/eba_alu.sv
hdl/eight_bit_cpu_alu_with_flags.sv
verif/tb.sv
